### hdl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Used by the channel interfaces, the sequencer and the top level.
package uer_pkg;

	// Counter width default and field widths
	localparam int COUNT_BITS_DEF = 20;
	localparam int TW_W           = 8;
	localparam int WIN_W          = 20;
	localparam int MAXE_W         = 20;
	localparam int BACKOFF_W      = 3;
	localparam int GAIN_W         = 17;
	localparam int OFFSET_W       = 25;
	localparam int HEIGHT_W       = 13;
	localparam int FRAC_BITS      = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = OFFSET_W;

	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_WINDOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_CYCLES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Q16     = 3'd5;

	// Register reset values
	localparam logic [TW_W-1:0]             TRIGGER_WIDTH_RST  = 8'd15;
	localparam logic [WIN_W-1:0]            WAIT_WINDOW_RST    = 20'd6000;
	localparam logic [MAXE_W-1:0]           MAX_ECHO_RST       = 20'd25000;
	localparam logic [BACKOFF_W-1:0]        BACKOFF_CYCLES_RST = 3'd5;
	localparam logic [GAIN_W-1:0]           GAIN_Q16_RST       = 17'd11436;
	localparam logic signed [OFFSET_W-1:0]  OFFSET_Q16_RST     = -25'sd9181594;

	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 13'd8191;

	typedef struct packed {
		logic [TW_W-1:0]            trigger_width;
		logic [WIN_W-1:0]           wait_window;
		logic [MAXE_W-1:0]          max_echo;
		logic [BACKOFF_W-1:0]       backoff_cycles;
		logic [GAIN_W-1:0]          gain_q16;
		logic signed [OFFSET_W-1:0] offset_q16;
	} uer_cfg_t;

	// Per-item status from the sequencer
	typedef struct packed {
		logic trig;
		logic upd;
		logic tout;
		logic backoff;
	} uer_flags_t;

	typedef enum logic [1:0] {
		PH_TRIGGER,
		PH_WAIT,
		PH_BACKOFF
	} uer_phase_t;

endpackage

### hdl/uer_if.sv
// Valid/ready channel interfaces for the echo ranger: sample, result and config.
// Depends on uer_pkg for field widths.
interface uer_sample_if;
	logic valid;
	logic ready;
	logic echo_level;

	modport source (output valid, output echo_level, input ready);
	modport sink (input valid, input echo_level, output ready);
endinterface

interface uer_result_if import uer_pkg::*;;
	logic                valid;
	logic                ready;
	logic                trigger_level;
	logic [HEIGHT_W-1:0] height_mm;
	logic                height_updated;
	logic                timed_out;
	logic                in_backoff;

	modport source (output valid, output trigger_level, output height_mm,
		output height_updated, output timed_out, output in_backoff, input ready);
	modport sink (input valid, input trigger_level, input height_mm,
		input height_updated, input timed_out, input in_backoff, output ready);
endinterface

interface uer_cfg_if import uer_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/ultrasonic_echo_ranger_core.sv
// Ultrasonic echo ranger core: one echo sample in, one status item out per tick.
// An accepted sample passes the input, sequencer and product stages, then the
// result register. Throughput: one item per cycle while result.ready is high;
// the limit is the sequencer state update. Asynchronous reset returns
// the sequencer to the trigger phase, height to zero and registers to defaults.
module ultrasonic_echo_ranger_core import uer_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	uer_sample_if.sink    sample,
	uer_result_if.source  result,
	uer_cfg_if.sink       cfg
);

	localparam int PROD_W = COUNT_BITS + GAIN_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int MM_W   = ACC_W - FRAC_BITS;

	uer_cfg_t cfg_q;

	// Pipeline valids and payload
	logic                  v1_q, v2_q, v3_q, ov_q;
	logic                  level_s1;
	uer_flags_t            flags_s2, flags_s3, flags_q, seq_flags;
	logic [COUNT_BITS-1:0] count_s2, seq_count;
	logic [PROD_W-1:0]     prod_s3;
	logic [HEIGHT_W-1:0]   height_q, height_new;

	logic                    out_free, s3_free, s2_free, s1_free, step;
	logic signed [ACC_W-1:0] acc;
	logic [MM_W-1:0]         mm;

	// Configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_width  <= TRIGGER_WIDTH_RST;
			cfg_q.wait_window    <= WAIT_WINDOW_RST;
			cfg_q.max_echo       <= MAX_ECHO_RST;
			cfg_q.backoff_cycles <= BACKOFF_CYCLES_RST;
			cfg_q.gain_q16       <= GAIN_Q16_RST;
			cfg_q.offset_q16     <= OFFSET_Q16_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TRIGGER_WIDTH:  cfg_q.trigger_width  <= cfg.data[TW_W-1:0];
				REG_WAIT_WINDOW:    cfg_q.wait_window    <= cfg.data[WIN_W-1:0];
				REG_MAX_ECHO:       cfg_q.max_echo       <= cfg.data[MAXE_W-1:0];
				REG_BACKOFF_CYCLES: cfg_q.backoff_cycles <= cfg.data[BACKOFF_W-1:0];
				REG_GAIN_Q16:       cfg_q.gain_q16       <= cfg.data[GAIN_W-1:0];
				REG_OFFSET_Q16:     cfg_q.offset_q16     <= cfg.data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage advance: each stage loads when its holder is empty or moving on
	assign out_free     = !ov_q || result.ready;
	assign s3_free      = !v3_q || out_free;
	assign s2_free      = !v2_q || s3_free;
	assign s1_free      = !v1_q || s2_free;
	assign sample.ready = s1_free;
	assign step         = v1_q && s2_free;

	uer_seq #(
		.COUNT_BITS (COUNT_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.level  (level_s1),
		.cfg    (cfg_q),
		.flags  (seq_flags),
		.count  (seq_count)
	);

	// Convert the product to millimetres, clamp at zero, saturate at the top
	assign acc = $signed({2'b00, prod_s3}) + ACC_W'($signed(cfg_q.offset_q16));
	assign mm  = acc[ACC_W-1:FRAC_BITS];

	always_comb begin
		height_new = height_q;
		if (flags_s3.upd) begin
			if (acc[ACC_W-1] || (acc == '0)) begin
				height_new = '0;
			end else if (mm > MM_W'(HEIGHT_MAX)) begin
				height_new = HEIGHT_MAX;
			end else begin
				height_new = mm[HEIGHT_W-1:0];
			end
		end
	end

	// Pipeline valid bits and height register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			v3_q     <= 1'b0;
			ov_q     <= 1'b0;
			height_q <= '0;
		end else begin
			if (s1_free) begin
				v1_q <= sample.valid;
			end
			if (s2_free) begin
				v2_q <= v1_q;
			end
			if (s3_free) begin
				v3_q <= v2_q;
			end
			if (out_free) begin
				ov_q <= v3_q;
				if (v3_q) begin
					height_q <= height_new;
				end
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (s1_free) begin
			level_s1 <= sample.echo_level;
		end
		if (s2_free) begin
			flags_s2 <= seq_flags;
			count_s2 <= seq_count;
		end
		if (s3_free) begin
			flags_s3 <= flags_s2;
			prod_s3  <= PROD_W'(count_s2) * PROD_W'(cfg_q.gain_q16);
		end
		if (out_free) begin
			flags_q <= flags_s3;
		end
	end

	assign result.valid          = ov_q;
	assign result.trigger_level  = flags_q.trig;
	assign result.height_mm      = height_q;
	assign result.height_updated = flags_q.upd;
	assign result.timed_out      = flags_q.tout;
	assign result.in_backoff     = flags_q.backoff;

endmodule

### hdl/uer_seq.sv
// Measurement sequencer: trigger, wait window and backoff phases, tick counters.
// Depends on uer_pkg for the phase enum, config and flag structs.
module uer_seq import uer_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  level,
	input  uer_cfg_t              cfg,
	output uer_flags_t            flags,
	output logic [COUNT_BITS-1:0] count
);

	localparam int CMP_W = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;
	localparam logic [COUNT_BITS-1:0] LIMIT = '1;

	uer_phase_t            phase_q, phase_d;
	logic [COUNT_BITS-1:0] pt_q, pt_d, et_q, et_d;
	logic                  seen_q, seen_d;
	logic [BACKOFF_W-1:0]  skip_q, skip_d, skip_dec;

	logic [COUNT_BITS-1:0] pt_inc, et_inc;
	logic [CMP_W-1:0]      win, tw;
	logic                  win_end, trig_end, below_max, done;

	// Saturating increments and window compares
	assign pt_inc    = (pt_q == LIMIT) ? LIMIT : pt_q + 1'b1;
	assign et_inc    = (et_q == LIMIT) ? LIMIT : et_q + 1'b1;
	assign win       = (cfg.wait_window == '0) ? CMP_W'(1) : CMP_W'(cfg.wait_window);
	assign tw        = (cfg.trigger_width == '0) ? CMP_W'(1) : CMP_W'(cfg.trigger_width);
	assign win_end   = CMP_W'(pt_inc) >= win;
	assign trig_end  = CMP_W'(pt_inc) >= tw;
	assign below_max = CMP_W'(et_q) < CMP_W'(cfg.max_echo);
	assign skip_dec  = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
	assign count     = et_q;

	// Hold state between accepted items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TRIGGER;
			pt_q    <= '0;
			et_q    <= '0;
			seen_q  <= 1'b0;
			skip_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pt_q    <= pt_d;
			et_q    <= et_d;
			seen_q  <= seen_d;
			skip_q  <= skip_d;
		end
	end

	// Next state and per-tick flags
	always_comb begin
		phase_d = phase_q;
		pt_d    = pt_q;
		et_d    = et_q;
		seen_d  = seen_q;
		skip_d  = skip_q;
		flags   = '0;
		done    = 1'b0;
		case (phase_q)
			PH_WAIT: begin
				pt_d = pt_inc;
				if (!seen_q) begin
					if (level) begin
						seen_d = 1'b1;
						et_d   = COUNT_BITS'(1);
					end
				end else if (level) begin
					et_d = et_inc;
				end else begin
					// falling edge closes the measurement
					done      = 1'b1;
					seen_d    = 1'b0;
					flags.upd = below_max;
					skip_d    = '0;
					phase_d   = PH_TRIGGER;
					pt_d      = '0;
				end
				if (!done && win_end) begin
					flags.tout = 1'b1;
					seen_d     = 1'b0;
					skip_d     = cfg.backoff_cycles;
					phase_d    = (cfg.backoff_cycles != '0) ? PH_BACKOFF : PH_TRIGGER;
					pt_d       = '0;
				end
			end
			PH_BACKOFF: begin
				flags.backoff = 1'b1;
				skip_d        = skip_dec;
				if (skip_dec == '0) begin
					phase_d = PH_TRIGGER;
					pt_d    = '0;
				end
			end
			default: begin
				flags.trig = 1'b1;
				pt_d       = pt_inc;
				if (trig_end) begin
					phase_d = PH_WAIT;
					pt_d    = '0;
					et_d    = '0;
					seen_d  = 1'b0;
				end
			end
		endcase
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for ultrasonic_echo_ranger_core: echo samples in, status items out.
// Depends on uer_pkg and the channel interfaces in hdl/uer_if.sv.

module tb_top import uer_pkg::*;;

	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_TICKS = 8;

	// Idle percentages: sender-heavy, receiver-heavy, none
	localparam int IDLE_LO = 31;
	localparam int IDLE_HI = 56;

	typedef struct packed {
		logic                trig;
		logic [HEIGHT_W-1:0] height;
		logic                upd;
		logic                tout;
		logic                backoff;
	} tick_result_t;

	typedef enum {SHOT_CLEAN, SHOT_HELD, SHOT_NONE, SHOT_NOISE} shot_kind_t;

	// Range predictor and store of expected status items
	class ranger_scoreboard;
		logic [TW_W-1:0]            trig_width;
		logic [WIN_W-1:0]           wait_win;
		logic [MAXE_W-1:0]          echo_max;
		logic [BACKOFF_W-1:0]       skip_cfg;
		logic [GAIN_W-1:0]          gain;
		logic signed [OFFSET_W-1:0] offset;

		uer_phase_t                ph;
		logic [COUNT_BITS_DEF-1:0] ticks;
		logic [COUNT_BITS_DEF-1:0] echo_cnt;
		logic                      high_seen;
		logic [BACKOFF_W-1:0]      skips;
		logic [HEIGHT_W-1:0]       height;

		tick_result_t expected_q[$];
		int           errors;

		function new();
			trig_width = TRIGGER_WIDTH_RST;
			wait_win   = WAIT_WINDOW_RST;
			echo_max   = MAX_ECHO_RST;
			skip_cfg   = BACKOFF_CYCLES_RST;
			gain       = GAIN_Q16_RST;
			offset     = OFFSET_Q16_RST;
			ph         = PH_TRIGGER;
			ticks      = '0;
			echo_cnt   = '0;
			high_seen  = 1'b0;
			skips      = '0;
			height     = '0;
			errors     = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_TRIGGER_WIDTH:  trig_width = val[TW_W-1:0];
				REG_WAIT_WINDOW:    wait_win   = val[WIN_W-1:0];
				REG_MAX_ECHO:       echo_max   = val[MAXE_W-1:0];
				REG_BACKOFF_CYCLES: skip_cfg   = val[BACKOFF_W-1:0];
				REG_GAIN_Q16:       gain       = val[GAIN_W-1:0];
				REG_OFFSET_Q16:     offset     = val[OFFSET_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [COUNT_BITS_DEF-1:0] bump(logic [COUNT_BITS_DEF-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		// Scale the echo count to millimetres, clamp at zero, saturate at the top
		function logic [HEIGHT_W-1:0] to_height(logic [COUNT_BITS_DEF-1:0] cnt);
			longint acc;
			acc = longint'(cnt) * longint'(gain) + longint'(offset);
			if (acc <= 0)
				return '0;
			acc = acc >>> FRAC_BITS;
			return (acc > longint'(HEIGHT_MAX)) ? HEIGHT_MAX : acc[HEIGHT_W-1:0];
		endfunction

		// Advance the predictor by one tick and store the status item it yields
		function void note_sample(logic lvl);
			tick_result_t r;
			logic done;
			logic [COUNT_BITS_DEF-1:0] win;
			logic [COUNT_BITS_DEF-1:0] tw;
			r = '0;
			done = 1'b0;
			case (ph)
				PH_WAIT: begin
					win = (wait_win == '0) ? COUNT_BITS_DEF'(1) : COUNT_BITS_DEF'(wait_win);
					ticks = bump(ticks);
					if (!high_seen) begin
						if (lvl) begin
							high_seen = 1'b1;
							echo_cnt = COUNT_BITS_DEF'(1);
						end
					end else if (lvl) begin
						echo_cnt = bump(echo_cnt);
					end else begin
						done = 1'b1;
						high_seen = 1'b0;
						if (echo_cnt < echo_max) begin
							height = to_height(echo_cnt);
							r.upd = 1'b1;
						end
						skips = '0;
						ph = PH_TRIGGER;
						ticks = '0;
					end
					if (!done && ticks >= win) begin
						r.tout = 1'b1;
						high_seen = 1'b0;
						skips = skip_cfg;
						ph = (skips != '0) ? PH_BACKOFF : PH_TRIGGER;
						ticks = '0;
					end
				end
				PH_BACKOFF: begin
					r.backoff = 1'b1;
					if (skips != '0)
						skips = skips - 1'b1;
					if (skips == '0) begin
						ph = PH_TRIGGER;
						ticks = '0;
					end
				end
				default: begin
					tw = (trig_width == '0) ? COUNT_BITS_DEF'(1) : COUNT_BITS_DEF'(trig_width);
					r.trig = 1'b1;
					ticks = bump(ticks);
					if (ticks >= tw) begin
						ph = PH_WAIT;
						ticks = '0;
						echo_cnt = '0;
						high_seen = 1'b0;
					end
				end
			endcase
			r.height = height;
			expected_q.push_back(r);
		endfunction

		function void cmp_field(string name, logic [HEIGHT_W-1:0] want,
			logic [HEIGHT_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		// Match one status item against the oldest expectation
		function void check_result(logic trig, logic [HEIGHT_W-1:0] hgt, logic upd,
			logic tout, logic backoff);
			tick_result_t want;
			if (expected_q.size() == 0) begin
				$error("status item with no expectation pending");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			cmp_field("trigger_level", HEIGHT_W'(want.trig), HEIGHT_W'(trig));
			cmp_field("height_mm", want.height, hgt);
			cmp_field("height_updated", HEIGHT_W'(want.upd), HEIGHT_W'(upd));
			cmp_field("timed_out", HEIGHT_W'(want.tout), HEIGHT_W'(tout));
			cmp_field("in_backoff", HEIGHT_W'(want.backoff), HEIGHT_W'(backoff));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	uer_sample_if smp();
	uer_result_if res();
	uer_cfg_if    cfg_ch();

	ultrasonic_echo_ranger_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.cfg    (cfg_ch)
	);

	ranger_scoreboard sb = new();

	int gap_pct   = IDLE_LO;
	int stall_pct = IDLE_HI;
	int quiet_cycles = 0;

	shot_kind_t  shot_kind;
	int unsigned shot_delay;
	int unsigned shot_len;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort when no channel moves an item for too long
	always @(posedge clk) begin
		if ((smp.valid === 1'b1 && smp.ready === 1'b1) ||
			(res.valid === 1'b1 && res.ready === 1'b1) ||
			(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Status item receiver: check accepted items, stall at random
	initial begin
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res.valid === 1'b1 && res.ready === 1'b1)
				sb.check_result(res.trigger_level, res.height_mm, res.height_updated,
					res.timed_out, res.in_backoff);
			res.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Choose the next echo level; plan a shot at the start of each wait window
	function automatic logic pick_level(int unsigned lmin, int unsigned lmax);
		int unsigned t;
		int unsigned win;
		int unsigned r;
		if (sb.ph != PH_WAIT)
			return logic'($urandom_range(0, 1));
		t = 32'(sb.ticks);
		win = (sb.wait_win == '0) ? 1 : 32'(sb.wait_win);
		if (t == 0) begin
			r = $urandom_range(0, 99);
			shot_len = $urandom_range(lmin, lmax);
			shot_delay = $urandom_range(0, (win / 4 > 20) ? 20 : win / 4);
			if (win > 5000 || r < 65) begin
				shot_kind = SHOT_CLEAN;
			end else if (r < 75) begin
				// drop the echo exactly on the last window tick
				shot_kind = SHOT_CLEAN;
				shot_delay = (win > shot_len) ? win - 1 - shot_len : 0;
			end else if (r < 83) begin
				shot_kind = SHOT_HELD;
			end else if (r < 90) begin
				shot_kind = SHOT_NONE;
			end else begin
				shot_kind = SHOT_NOISE;
			end
		end
		case (shot_kind)
			SHOT_CLEAN: return (t >= shot_delay) && (t < shot_delay + shot_len);
			SHOT_HELD:  return t >= shot_delay;
			SHOT_NONE:  return 1'b0;
			default:    return logic'($urandom_range(0, 1));
		endcase
	endfunction

	// Offer one echo sample, with a random gap first; hold valid for the next item
	task automatic send_level(logic lvl);
		while ($urandom_range(0, 99) < gap_pct) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.echo_level <= lvl;
		do @(posedge clk); while (smp.ready !== 1'b1);
		sb.note_sample(lvl);
	endtask

	// Drain, reprogram every register, then drive a fixed pattern and random ticks
	task automatic run_setting(int tw, int win, int maxe, int bo, int gain, int off,
		int gap, int stall, string pat, int n_rand, int lmin, int lmax);
		logic [CFG_IDX_W-1:0]  idx [6];
		logic [CFG_DATA_W-1:0] vals [6];
		idx = '{REG_TRIGGER_WIDTH, REG_WAIT_WINDOW, REG_MAX_ECHO,
			REG_BACKOFF_CYCLES, REG_GAIN_Q16, REG_OFFSET_Q16};
		vals = '{CFG_DATA_W'(tw), CFG_DATA_W'(win), CFG_DATA_W'(maxe),
			CFG_DATA_W'(bo), CFG_DATA_W'(gain), CFG_DATA_W'(off)};
		smp.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 6; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data <= vals[i];
			do @(posedge clk); while (cfg_ch.ready !== 1'b1);
			sb.note_config(idx[i], vals[i]);
		end
		cfg_ch.valid <= 1'b0;
		gap_pct = gap;
		stall_pct = stall;
		for (int i = 0; i < pat.len(); i++)
			if (pat[i] == "0" || pat[i] == "1")
				send_level(pat[i] == "1");
		for (int i = 0; i < n_rand; i++)
			send_level(pick_level(lmin, lmax));
	endtask

	initial begin
		arst_n = 1'b0;
		smp.valid <= 1'b0;
		smp.echo_level <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ignored echo in trigger, level start, held echo timeout, backoff,
		// count at max on the last window tick, no-echo timeout
		run_setting(2, 4, 3, 2, 131071, 16777215, IDLE_LO, IDLE_HI,
			"11 10 00 0001 00 00 1110 00 0000 00", 0, 1, 1);
		// Directed: zero trigger width and zero window, no backoff
		run_setting(0, 0, 0, 0, 0, -16777216, IDLE_LO, IDLE_HI, "1 1 0 0", 0, 1, 1);
		// Directed: negative height clamps to zero
		run_setting(1, 8, 25000, 1, 11436, -9181594, IDLE_LO, IDLE_HI, "0 010", 0, 1, 1);

		// Random: sender idles less, receiver more
		run_setting(15, 200, 150, 5, 131071, -9181594, IDLE_LO, IDLE_HI, "", 200, 1, 180);
		run_setting(3, 40, 30, 3, 65536, -655360, IDLE_LO, IDLE_HI, "", 140, 1, 38);

		// Random: the other way round
		run_setting(8, 300, 250, 1, 131071, -16777216, IDLE_HI, IDLE_LO, "", 220, 1, 290);
		run_setting(0, 0, 0, 0, 0, 0, IDLE_HI, IDLE_LO, "", 100, 1, 2);
		run_setting(2, 25, 1048575, 2, 100000, 5000000, IDLE_HI, IDLE_LO, "", 140, 1, 24);

		// Random: no idling; zero max echo, then all registers at their top values
		run_setting(1, 30, 0, 7, 70000, 1, 0, 0, "", 120, 1, 25);
		run_setting(4, 60, 45, 6, 98304, -1310720, 0, 0, "", 160, 1, 50);
		run_setting(255, 1048575, 1048575, 7, 131071, 16777215, 0, 0, "", 640, 100, 300);

		// Drain remaining status items, then let the pipeline settle
		smp.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
